// ===== hw/rtl/sscm_pkg.sv =====
// ----------------------------------------------------------------------------
// Slab size class mapper package
// Class region table, shared types and fixed constants.
// ----------------------------------------------------------------------------
package sscm_pkg;

  localparam int REGION_CNT        = 8;
  localparam int REGION_W          = 3;
  localparam int IDX_W             = 9;
  localparam int SHIFT_W           = 4;
  localparam int BASE_W            = 17;
  localparam int SMALL_SLAB_PAGES  = 16;
  localparam int SMALL_CLASS_BYTES = 1024;
  localparam int BITMAP_MASK       = 63;
  localparam int BITMAP_SHIFT      = 6;
  localparam int WORD_SHIFT        = 3;
  localparam int MAX_STEP_BYTES    = 16384;

  typedef struct packed {
    logic [BASE_W-1:0]  base;
    logic [SHIFT_W-1:0] shift;
    logic [IDX_W-1:0]   idx_base;
  } region_t;

  typedef struct packed {
    logic             hit;
    logic [IDX_W-1:0] idx;
  } cls_info_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

  // upper bound of each region
  function automatic logic [BASE_W-1:0] region_top(input logic [REGION_W-1:0] i);
    logic [BASE_W-1:0] v;
    case (i)
      3'd0:    v = BASE_W'(128);
      3'd1:    v = BASE_W'(256);
      3'd2:    v = BASE_W'(512);
      3'd3:    v = BASE_W'(1024);
      3'd4:    v = BASE_W'(4096);
      3'd5:    v = BASE_W'(16384);
      3'd6:    v = BASE_W'(65536);
      default: v = '0;
    endcase
    return v;
  endfunction

  // base size, step exponent and first class index of a region
  function automatic region_t region_of(input logic [REGION_W-1:0] code);
    region_t r;
    case (code)
      3'd0:    r = '{base: BASE_W'(0),     shift: SHIFT_W'(3),  idx_base: IDX_W'(0)};
      3'd1:    r = '{base: BASE_W'(128),   shift: SHIFT_W'(4),  idx_base: IDX_W'(16)};
      3'd2:    r = '{base: BASE_W'(256),   shift: SHIFT_W'(5),  idx_base: IDX_W'(24)};
      3'd3:    r = '{base: BASE_W'(512),   shift: SHIFT_W'(6),  idx_base: IDX_W'(32)};
      3'd4:    r = '{base: BASE_W'(1024),  shift: SHIFT_W'(8),  idx_base: IDX_W'(40)};
      3'd5:    r = '{base: BASE_W'(4096),  shift: SHIFT_W'(10), idx_base: IDX_W'(52)};
      3'd6:    r = '{base: BASE_W'(16384), shift: SHIFT_W'(12), idx_base: IDX_W'(64)};
      default: r = '{base: BASE_W'(65536), shift: SHIFT_W'(14), idx_base: IDX_W'(76)};
    endcase
    return r;
  endfunction

endpackage

// ===== hw/rtl/sscm_class_map.sv =====
// ----------------------------------------------------------------------------
// Slab size class lookup
// Rounds a request up to its class block size and class index.
// ----------------------------------------------------------------------------
module sscm_class_map #(
  parameter int SMALL_LIMIT_BYTES = 262144,
  parameter int CLASS_LIMIT       = 128,
  parameter int BW                = 19
) (
  input  logic [31:0]              req_size,
  output sscm_pkg::cls_info_t      info,
  output logic [BW-1:0]            block_bytes
);

  localparam int RW = $clog2(SMALL_LIMIT_BYTES + 1);
  localparam int XW = ((RW > sscm_pkg::BASE_W) ? RW : sscm_pkg::BASE_W) + 1;

  logic [sscm_pkg::REGION_W-1:0] code;
  sscm_pkg::region_t             reg_sel;
  logic [XW-1:0]                 rx;
  logic [XW-1:0]                 d;
  logic [XW-1:0]                 mask;
  logic [XW-1:0]                 k;
  logic [XW-1:0]                 kk;
  logic [XW-1:0]                 b;
  logic [sscm_pkg::IDX_W-1:0]    idx;
  logic                          too_big;

  always_comb begin
    rx      = XW'(req_size[RW-1:0]);
    too_big = req_size > 32'(SMALL_LIMIT_BYTES);
    code    = '0;
    for (int i = 0; i < sscm_pkg::REGION_CNT - 1; i++) begin
      if (rx > XW'(sscm_pkg::region_top(sscm_pkg::REGION_W'(i)))) begin
        code = code + 1'b1;
      end
    end
    reg_sel = sscm_pkg::region_of(code);
    d       = rx - XW'(reg_sel.base);
    mask    = (XW'(1) << reg_sel.shift) - XW'(1);
    k       = (d + mask) >> reg_sel.shift;
    kk      = (k == '0) ? XW'(1) : k;
    b       = XW'(reg_sel.base) + (kk << reg_sel.shift);
    idx     = reg_sel.idx_base + sscm_pkg::IDX_W'(kk) - sscm_pkg::IDX_W'(1);
  end

  assign info.hit    = !too_big && (b <= XW'(SMALL_LIMIT_BYTES)) &&
                       (idx < sscm_pkg::IDX_W'(CLASS_LIMIT));
  assign info.idx    = idx;
  assign block_bytes = BW'(b);

endmodule

// ===== hw/rtl/sscm_div.sv =====
// ----------------------------------------------------------------------------
// Restoring divider
// One quotient bit per cycle; quotient valid when done pulses.
// ----------------------------------------------------------------------------
module sscm_div #(
  parameter int DW = 24,
  parameter int VW = 24
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic [DW-1:0]        dividend,
  input  logic [VW-1:0]        divisor,
  output logic [DW-1:0]        quotient,
  output sscm_pkg::div_stat_t  stat
);

  localparam int CNTW = $clog2(DW + 1);

  logic            busy_r, busy_nxt;
  logic            done_r, done_nxt;
  logic [CNTW-1:0] cnt_r, cnt_nxt;
  logic [VW-1:0]   rem_r, rem_nxt;
  logic [DW-1:0]   quo_r, quo_nxt;
  logic [VW-1:0]   dsr_r, dsr_nxt;
  logic [VW:0]     trial;
  logic [VW:0]     diff;
  logic            ge;

  always_comb begin
    trial    = {rem_r, quo_r[DW-1]};
    diff     = trial - {1'b0, dsr_r};
    ge       = trial >= {1'b0, dsr_r};
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    dsr_nxt  = dsr_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CNTW'(DW);
      rem_nxt  = '0;
      quo_nxt  = dividend;
      dsr_nxt  = divisor;
    end else if (busy_r) begin
      rem_nxt = ge ? diff[VW-1:0] : trial[VW-1:0];
      quo_nxt = {quo_r[DW-2:0], ge};
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CNTW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    dsr_r <= dsr_nxt;
  end

  assign quotient = quo_r;
  assign stat     = '{busy: busy_r, done: done_r};

endmodule

// ===== hw/rtl/slab_size_class_mapper.sv =====
// ----------------------------------------------------------------------------
// Slab size class mapper
// Maps a request size to its size class, slab pages, block capacity and
// slab header size.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel in_valid/in_stall carries in_req_size. One request is
//   worked at a time; in_stall is high from acceptance until the result has
//   been moved into the output register.
//   Output channel out_valid/out_stall carries the result fields. The output
//   register holds a result while out_stall is high; the next request can be
//   accepted meanwhile and waits in its last step until the register frees.
//   Path: a request that maps to no class goes from the class step straight
//   to the output step; one whose slab has no room past the header leaves
//   after the total step. A mapped request passes the class, page, total,
//   divide and fit steps. The divider, one quotient bit per cycle, runs once
//   for the capacity estimate, followed by capacity check steps that lower
//   the estimate until it fits. The slab page count comes from a reciprocal
//   multiply in a single step.
//   A new request is accepted only once the last result has entered the
//   output register, which can wait while out_stall holds that register.
//   Reset (rst_n low, synchronous) empties the output register and returns
//   the sequencer to idle.
// ----------------------------------------------------------------------------
module slab_size_class_mapper #(
  parameter int PAGE_BYTES        = 4096,
  parameter int SEGMENT_BYTES     = 2097152,
  parameter int SMALL_LIMIT_BYTES = 262144,
  parameter int HEADER_BASE_BYTES = 64,
  parameter int CLASS_LIMIT       = 128
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] in_req_size,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_size_ok,
  output logic [6:0]  out_class_index,
  output logic [18:0] out_class_block_bytes,
  output logic [8:0]  out_slab_page_count,
  output logic [16:0] out_slab_block_capacity,
  output logic [12:0] out_header_bytes
);

  localparam int BW    = $clog2(SMALL_LIMIT_BYTES + sscm_pkg::MAX_STEP_BYTES + 1);
  localparam int CAP_P = SEGMENT_BYTES / PAGE_BYTES / 2;
  localparam int PW    = $clog2(CAP_P + 2);
  localparam int PGW   = $clog2(PAGE_BYTES + 1);
  localparam int TW    = $clog2(SEGMENT_BYTES / 2 + 1);
  localparam int CW    = (TW > 17) ? TW : 17;
  localparam int DW    = (TW + 3 > BW + 4) ? TW + 3 : BW + 4;
  localparam int VW    = (PGW > BW + 4) ? PGW : BW + 4;
  localparam int H8    = ((HEADER_BASE_BYTES + 7) / 8) * 8;
  localparam int FW    = CW + BW + 1;
  localparam int MW    = CW + 4;
  // page count: ceil(8*b/PAGE_BYTES) by reciprocal multiply, exact below 2^NW
  localparam int NW    = BW + 4;
  localparam int PG_SH = NW + $clog2(PAGE_BYTES);
  localparam int PRW   = 2 * NW + 1;
  localparam longint unsigned PG_RECIP =
    ((64'd1 << PG_SH) + 64'(PAGE_BYTES) - 64'd1) / 64'(PAGE_BYTES);

  localparam int       ST_W    = 3;
  localparam bit [2:0] ST_IDLE = 3'd0;
  localparam bit [2:0] ST_CLS  = 3'd1;
  localparam bit [2:0] ST_PAGE = 3'd2;
  localparam bit [2:0] ST_TOT  = 3'd3;
  localparam bit [2:0] ST_CDIV = 3'd4;
  localparam bit [2:0] ST_FIT  = 3'd5;
  localparam bit [2:0] ST_OUT  = 3'd6;

  logic [ST_W-1:0]            state_r, state_nxt;
  logic [31:0]                req_r, req_nxt;
  logic                       ok_r, ok_nxt;
  logic [sscm_pkg::IDX_W-1:0] idx_r, idx_nxt;
  logic [BW-1:0]              b_r, b_nxt;
  logic [PW-1:0]              pages_r, pages_nxt;
  logic [TW-1:0]              tp_r, tp_nxt;
  logic [CW-1:0]              cap_r, cap_nxt;
  logic [CW-1:0]              best_r, best_nxt;
  logic [MW-1:0]              meta_r, meta_nxt;

  logic                       out_valid_r, out_valid_nxt;
  logic                       out_ok_r, out_ok_nxt;
  logic [6:0]                 out_idx_r, out_idx_nxt;
  logic [18:0]                out_b_r, out_b_nxt;
  logic [8:0]                 out_pages_r, out_pages_nxt;
  logic [16:0]                out_cap_r, out_cap_nxt;
  logic [12:0]                out_meta_r, out_meta_nxt;

  sscm_pkg::cls_info_t        cls_info;
  logic [BW-1:0]              cls_b;
  logic                       div_start;
  logic [DW-1:0]              div_dividend;
  logic [VW-1:0]              div_divisor;
  logic [DW-1:0]              div_q;
  sscm_pkg::div_stat_t        div_stat;

  logic [NW-1:0]              pg_num;
  logic [PRW-1:0]             pg_prod;
  logic [NW-1:0]              pg_q;
  logic [NW-1:0]              pg_min;
  logic [PW+PGW-1:0]          total_full;
  logic [TW-1:0]              total;
  logic [TW-1:0]              tp_c;
  logic [CW-1:0]              words;
  logic [FW-1:0]              word_bytes;
  logic [FW-1:0]              used;
  logic                       fits;
  logic                       out_load;

  sscm_class_map #(
    .SMALL_LIMIT_BYTES (SMALL_LIMIT_BYTES),
    .CLASS_LIMIT       (CLASS_LIMIT),
    .BW                (BW)
  ) u_class_map (
    .req_size    (req_r),
    .info        (cls_info),
    .block_bytes (cls_b)
  );

  sscm_div #(
    .DW (DW),
    .VW (VW)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .quotient (div_q),
    .stat     (div_stat)
  );

  always_comb begin
    pg_num     = NW'({b_r, 3'b000}) + NW'(PAGE_BYTES - 1);
    pg_prod    = PRW'(pg_num) * PRW'(PG_RECIP);
    pg_q       = NW'(pg_prod >> PG_SH);
    pg_min     = ((b_r <= BW'(sscm_pkg::SMALL_CLASS_BYTES)) &&
                  (pg_q < NW'(sscm_pkg::SMALL_SLAB_PAGES))) ?
                 NW'(sscm_pkg::SMALL_SLAB_PAGES) : pg_q;
    total_full = (PW + PGW)'(pages_r) * (PW + PGW)'(PAGE_BYTES);
    total      = TW'(total_full);
    tp_c       = total - TW'(H8);
    words      = CW'(({1'b0, cap_r} + (CW + 1)'(sscm_pkg::BITMAP_MASK))
                     >> sscm_pkg::BITMAP_SHIFT);
    word_bytes = FW'(words) << sscm_pkg::WORD_SHIFT;
    used       = FW'((CW + BW)'(cap_r) * (CW + BW)'(b_r)) + word_bytes;
    fits       = used <= FW'(tp_r);
    out_load   = (state_r == ST_OUT) && (!out_valid_r || !out_stall);
  end

  always_comb begin
    state_nxt    = state_r;
    req_nxt      = req_r;
    ok_nxt       = ok_r;
    idx_nxt      = idx_r;
    b_nxt        = b_r;
    pages_nxt    = pages_r;
    tp_nxt       = tp_r;
    cap_nxt      = cap_r;
    best_nxt     = best_r;
    meta_nxt     = meta_r;
    div_start    = 1'b0;
    div_dividend = DW'({tp_c, 3'b000});
    div_divisor  = VW'({b_r, 3'b000}) + VW'(1);
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          req_nxt   = in_req_size;
          state_nxt = ST_CLS;
        end
      end
      ST_CLS: begin
        ok_nxt   = cls_info.hit;
        idx_nxt  = cls_info.idx;
        b_nxt    = cls_b;
        best_nxt = '0;
        meta_nxt = '0;
        if (cls_info.hit) begin
          state_nxt = ST_PAGE;
        end else begin
          state_nxt = ST_OUT;
        end
      end
      ST_PAGE: begin
        pages_nxt = (pg_min > NW'(CAP_P)) ? PW'(CAP_P) : PW'(pg_min);
        state_nxt = ST_TOT;
      end
      ST_TOT: begin
        tp_nxt = tp_c;
        if (total <= TW'(H8)) begin
          state_nxt = ST_OUT;
        end else begin
          div_start = 1'b1;
          state_nxt = ST_CDIV;
        end
      end
      ST_CDIV: begin
        if (div_stat.done) begin
          cap_nxt   = div_q[CW-1:0];
          state_nxt = ST_FIT;
        end
      end
      ST_FIT: begin
        if (cap_r == '0) begin
          state_nxt = ST_OUT;
        end else if (fits) begin
          best_nxt  = cap_r;
          meta_nxt  = MW'(H8) + MW'(word_bytes);
          state_nxt = ST_OUT;
        end else begin
          cap_nxt = cap_r - 1'b1;
        end
      end
      ST_OUT: begin
        if (out_load) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r && out_stall;
    out_ok_nxt    = out_ok_r;
    out_idx_nxt   = out_idx_r;
    out_b_nxt     = out_b_r;
    out_pages_nxt = out_pages_r;
    out_cap_nxt   = out_cap_r;
    out_meta_nxt  = out_meta_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
      out_ok_nxt    = ok_r;
      out_idx_nxt   = ok_r ? 7'(idx_r) : '0;
      out_b_nxt     = ok_r ? 19'(b_r) : '0;
      out_pages_nxt = ok_r ? 9'(pages_r) : '0;
      out_cap_nxt   = ok_r ? 17'(best_r) : '0;
      out_meta_nxt  = ok_r ? 13'(meta_r) : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    req_r       <= req_nxt;
    ok_r        <= ok_nxt;
    idx_r       <= idx_nxt;
    b_r         <= b_nxt;
    pages_r     <= pages_nxt;
    tp_r        <= tp_nxt;
    cap_r       <= cap_nxt;
    best_r      <= best_nxt;
    meta_r      <= meta_nxt;
    out_ok_r    <= out_ok_nxt;
    out_idx_r   <= out_idx_nxt;
    out_b_r     <= out_b_nxt;
    out_pages_r <= out_pages_nxt;
    out_cap_r   <= out_cap_nxt;
    out_meta_r  <= out_meta_nxt;
  end

  assign in_stall                = (state_r != ST_IDLE);
  assign out_valid               = out_valid_r;
  assign out_size_ok             = out_ok_r;
  assign out_class_index         = out_idx_r;
  assign out_class_block_bytes   = out_b_r;
  assign out_slab_page_count     = out_pages_r;
  assign out_slab_block_capacity = out_cap_r;
  assign out_header_bytes        = out_meta_r;

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("request accepted but input not stalled");

  a_reject_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_size_ok |-> (out_class_index == '0 && out_class_block_bytes == '0 &&
      out_slab_page_count == '0 && out_slab_block_capacity == '0 && out_header_bytes == '0))
    else $error("rejected request with nonzero fields");

  a_header_aligned: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_header_bytes[2:0] == 3'd0)
    else $error("header size not 8-byte aligned");

  a_div_done_state: assert property (@(posedge clk) disable iff (!rst_n)
    div_stat.done |-> state_r == ST_CDIV)
    else $error("divider finished outside a divide step");

endmodule
